FILE: rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Types, constants and helper functions shared by the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    localparam int unsigned ByteW      = 8;
    localparam int unsigned MaxResults = 3;
    localparam int unsigned CntW       = $clog2(MaxResults + 1);

    localparam logic [ByteW-1:0] ChPercent = 8'h25;
    localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
    localparam logic [ByteW-1:0] ChSpace   = 8'h20;
    localparam logic [ByteW-1:0] ChDel     = 8'h7F;
    localparam logic [ByteW-1:0] CtrlLimit = 8'h20;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_PCT     = 2'd1,
        MODE_DIGIT   = 2'd2,
        MODE_DISCARD = 2'd3
    } t_mode;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             byte_valid;
        logic             string_done;
        logic             forbidden_error;
    } t_result;

    typedef struct packed {
        logic [CntW-1:0] cnt;
        t_result [MaxResults-1:0] res;
    } t_bundle;

    function automatic logic is_hex(input logic [ByteW-1:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) ||
                 (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Low nibble of a hex digit; letters carry +9 on their low nibble.
    function automatic logic [3:0] hex_val(input logic [ByteW-1:0] c);
        if (c[6]) begin
            hex_val = c[3:0] + 4'd9;
        end else begin
            hex_val = c[3:0];
        end
    endfunction

    function automatic t_result byte_res(input logic [ByteW-1:0] b);
        byte_res = '{out_byte: b, byte_valid: 1'b1, string_done: 1'b0,
                     forbidden_error: 1'b0};
    endfunction

    // Ordinary byte copy: plus becomes space.
    function automatic t_result plain_res(input logic [ByteW-1:0] c);
        plain_res = byte_res((c == ChPlus) ? ChSpace : c);
    endfunction

    function automatic t_result done_res();
        done_res = '{out_byte: '0, byte_valid: 1'b0, string_done: 1'b1,
                     forbidden_error: 1'b0};
    endfunction

    function automatic t_result err_res();
        err_res = '{out_byte: '0, byte_valid: 1'b0, string_done: 1'b1,
                    forbidden_error: 1'b1};
    endfunction

endpackage

FILE: rtl/upd_decode.sv
// ----------------------------------------------------------------------------
// upd_decode
// Input register, escape state and the per-item decode into a result bundle.
// ----------------------------------------------------------------------------
module upd_decode (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [upd_pkg::ByteW-1:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic                      i_s_axis_tlast,   // is_end
    input  logic                      i_bundle_free,
    output logic                      o_load,
    output upd_pkg::t_bundle          o_bundle
);

    logic                      r_in_valid;
    logic [upd_pkg::ByteW-1:0] r_in_byte;
    logic                      r_in_end;
    upd_pkg::t_mode            r_mode, n_mode;
    logic [upd_pkg::ByteW-1:0] r_held, n_held;
    logic [upd_pkg::ByteW-1:0] dec_val;
    upd_pkg::t_bundle          bnd;
    logic                      s_take;

    assign o_load          = r_in_valid && i_bundle_free;
    assign o_s_axis_tready = !r_in_valid || o_load;
    assign s_take          = i_s_axis_tvalid && o_s_axis_tready;
    assign dec_val         = {upd_pkg::hex_val(r_held), upd_pkg::hex_val(r_in_byte)};
    assign o_bundle        = bnd;

    always_comb begin
        bnd    = '0;
        n_mode = r_mode;
        n_held = r_held;
        if (r_in_end) begin
            n_mode = upd_pkg::MODE_PLAIN;
            unique case (r_mode)
                upd_pkg::MODE_PLAIN: begin
                    bnd.res[0] = upd_pkg::done_res();
                    bnd.cnt    = 2'd1;
                end
                upd_pkg::MODE_PCT: begin
                    bnd.res[0] = upd_pkg::byte_res(upd_pkg::ChPercent);
                    bnd.res[1] = upd_pkg::done_res();
                    bnd.cnt    = 2'd2;
                end
                upd_pkg::MODE_DIGIT: begin
                    bnd.res[0] = upd_pkg::byte_res(upd_pkg::ChPercent);
                    bnd.res[1] = upd_pkg::byte_res(r_held);
                    bnd.res[2] = upd_pkg::done_res();
                    bnd.cnt    = 2'd3;
                end
                upd_pkg::MODE_DISCARD: begin
                    bnd.cnt = 2'd0;
                end
                default: ;
            endcase
        end else begin
            unique case (r_mode)
                upd_pkg::MODE_PLAIN: begin
                    if (r_in_byte == upd_pkg::ChPercent) begin
                        n_mode = upd_pkg::MODE_PCT;
                    end else begin
                        bnd.res[0] = upd_pkg::plain_res(r_in_byte);
                        bnd.cnt    = 2'd1;
                    end
                end
                upd_pkg::MODE_PCT: begin
                    if (upd_pkg::is_hex(r_in_byte)) begin
                        n_held = r_in_byte;
                        n_mode = upd_pkg::MODE_DIGIT;
                    end else begin
                        // bad escape: emit the percent, re-handle the byte
                        bnd.res[0] = upd_pkg::byte_res(upd_pkg::ChPercent);
                        if (r_in_byte == upd_pkg::ChPercent) begin
                            bnd.cnt = 2'd1;
                        end else begin
                            bnd.res[1] = upd_pkg::plain_res(r_in_byte);
                            bnd.cnt    = 2'd2;
                            n_mode     = upd_pkg::MODE_PLAIN;
                        end
                    end
                end
                upd_pkg::MODE_DIGIT: begin
                    if (upd_pkg::is_hex(r_in_byte)) begin
                        bnd.cnt = 2'd1;
                        if (dec_val < upd_pkg::CtrlLimit || dec_val == upd_pkg::ChDel) begin
                            bnd.res[0] = upd_pkg::err_res();
                            n_mode     = upd_pkg::MODE_DISCARD;
                        end else begin
                            bnd.res[0] = upd_pkg::byte_res(dec_val);
                            n_mode     = upd_pkg::MODE_PLAIN;
                        end
                    end else begin
                        bnd.res[0] = upd_pkg::byte_res(upd_pkg::ChPercent);
                        bnd.res[1] = upd_pkg::plain_res(r_held);
                        if (r_in_byte == upd_pkg::ChPercent) begin
                            bnd.cnt = 2'd2;
                            n_mode  = upd_pkg::MODE_PCT;
                        end else begin
                            bnd.res[2] = upd_pkg::plain_res(r_in_byte);
                            bnd.cnt    = 2'd3;
                            n_mode     = upd_pkg::MODE_PLAIN;
                        end
                    end
                end
                upd_pkg::MODE_DISCARD: begin
                    bnd.cnt = 2'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= upd_pkg::MODE_PLAIN;
            r_held     <= '0;
        end else begin
            if (s_take) begin
                r_in_valid <= 1'b1;
            end else if (o_load) begin
                r_in_valid <= 1'b0;
            end
            if (o_load) begin
                r_mode <= n_mode;
                r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

endmodule

FILE: rtl/upd_outq.sv
// ----------------------------------------------------------------------------
// upd_outq
// Result register: holds one item's bundle and drains it one result a cycle while the output is ready.
// ----------------------------------------------------------------------------
module upd_outq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  upd_pkg::t_bundle          i_bundle,
    output logic                      o_free,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [upd_pkg::ByteW-1:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]                o_m_axis_tuser,   // [0] byte_valid, [1] forbidden_error
    output logic                      o_m_axis_tlast    // string_done
);

    logic [upd_pkg::CntW-1:0]                 r_cnt;
    upd_pkg::t_result [upd_pkg::MaxResults-1:0] r_res;
    logic                                     pop;

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign o_free          = (r_cnt == '0) || (r_cnt == 2'd1 && pop);
    assign o_m_axis_tdata  = r_res[0].out_byte;
    assign o_m_axis_tuser  = {r_res[0].forbidden_error, r_res[0].byte_valid};
    assign o_m_axis_tlast  = r_res[0].string_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_bundle.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_bundle.res;
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("bundle loaded over undelivered results");

    a_err_ends_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1]) |-> o_m_axis_tlast)
        else $error("error result without string end");

    a_byte_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tlast))
        else $error("byte result flagged as string end");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_load) |=> (r_cnt == $past(r_cnt) - 2'd1))
        else $error("result count did not step down on pop");

endmodule

FILE: rtl/url_percent_decoder_unit.sv
// An accepted item waits in the input register until the result register is free,
// then its results are loaded there and presented. Throughput: one item per cycle
// while each item yields at most one result and the output is ready; an item with
// k results (k up to 3) holds the result register, draining one result per cycle
// while the output is ready, which sets the rate. Reset (i_rst_n low, synchronous)
// returns to plain copy mode and empties the input and result registers.
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// Streaming URI percent decoder, one byte per item, end item closes a string.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [upd_pkg::ByteW-1:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic                      i_s_axis_tlast,   // is_end
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [upd_pkg::ByteW-1:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]                o_m_axis_tuser,   // [0] byte_valid, [1] forbidden_error
    output logic                      o_m_axis_tlast    // string_done
);

    logic             load;
    logic             bundle_free;
    upd_pkg::t_bundle bundle;

    upd_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_bundle_free   (bundle_free),
        .o_load          (load),
        .o_bundle        (bundle)
    );

    upd_outq u_outq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (load),
        .i_bundle        (bundle),
        .o_free          (bundle_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
